@@ sv/iase_pkg.sv @@
// Package for the indexed array store engine: operation and status codes,
// controller states, and the command and status types between the controller and datapath.
// Has no dependencies.
package iase_pkg;

	typedef enum logic [2:0] {
		OP_CLEAR  = 3'd0,
		OP_APPEND = 3'd1,
		OP_INSERT = 3'd2,
		OP_DELETE = 3'd3,
		OP_SORT   = 3'd4,
		OP_FIND   = 3'd5,
		OP_MAX    = 3'd6,
		OP_READ   = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_POS   = 3'd1,
		ST_FULL  = 3'd2,
		ST_EMPTY = 3'd3,
		ST_MISS  = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS,
		S_INS_WR,
		S_DEL,
		S_DEL_WR,
		S_SORT,
		S_SORT_KEY,
		S_SORT_J,
		S_SORT_CMP,
		S_SCAN,
		S_SCAN_CMP,
		S_READ_RD,
		S_READ_CAP,
		S_FIN
	} state_t;

	typedef enum logic [4:0] {
		DP_NONE,
		DP_ACCEPT,
		DP_INS_RD,
		DP_INS_WR,
		DP_INS_PUT,
		DP_DEL_RD,
		DP_DEL_WR,
		DP_DEL_END,
		DP_SORT_RD,
		DP_SORT_KEY,
		DP_SORT_JRD,
		DP_SORT_SHIFT,
		DP_SORT_PUT,
		DP_SCAN_RD,
		DP_SCAN_CMP,
		DP_READ_RD,
		DP_READ_CAP,
		DP_OUT
	} dp_act_t;

	typedef struct packed {
		logic err;
		logic a_ge_pos;
		logic a1_lt_cnt;
		logic a_lt_cnt;
		logic j_nz;
		logic gt;
		logic out_free;
	} dp_sts_t;

endpackage

@@ sv/iase_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Has no dependencies.
module iase_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ sv/iase_ctrl.sv @@
// Controller state machine of the indexed array store engine.
// Depends on iase_pkg.
module iase_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [2:0]        operation,
	input  iase_pkg::dp_sts_t sts,
	output iase_pkg::dp_act_t act
);
	import iase_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (sts.err) begin
						state_d = S_FIN;
					end else begin
						case (op_t'(operation))
							OP_INSERT: state_d = S_INS;
							OP_DELETE: state_d = S_DEL;
							OP_SORT:   state_d = S_SORT;
							OP_FIND:   state_d = S_SCAN;
							OP_MAX:    state_d = S_SCAN;
							OP_READ:   state_d = S_READ_RD;
							default:   state_d = S_FIN;
						endcase
					end
				end
			end
			S_INS:      state_d = sts.a_ge_pos ? S_INS_WR : S_FIN;
			S_INS_WR:   state_d = S_INS;
			S_DEL:      state_d = sts.a1_lt_cnt ? S_DEL_WR : S_FIN;
			S_DEL_WR:   state_d = S_DEL;
			S_SORT:     state_d = sts.a_lt_cnt ? S_SORT_KEY : S_FIN;
			S_SORT_KEY: state_d = S_SORT_J;
			S_SORT_J:   state_d = sts.j_nz ? S_SORT_CMP : S_SORT;
			S_SORT_CMP: state_d = sts.gt ? S_SORT_J : S_SORT;
			S_SCAN:     state_d = sts.a_lt_cnt ? S_SCAN_CMP : S_FIN;
			S_SCAN_CMP: state_d = S_SCAN;
			S_READ_RD:  state_d = S_READ_CAP;
			S_READ_CAP: state_d = S_FIN;
			S_FIN:      state_d = sts.out_free ? S_IDLE : S_FIN;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		act = DP_NONE;
		case (state_q)
			S_IDLE:     act = req_valid ? DP_ACCEPT : DP_NONE;
			S_INS:      act = sts.a_ge_pos ? DP_INS_RD : DP_INS_PUT;
			S_INS_WR:   act = DP_INS_WR;
			S_DEL:      act = sts.a1_lt_cnt ? DP_DEL_RD : DP_DEL_END;
			S_DEL_WR:   act = DP_DEL_WR;
			S_SORT:     act = sts.a_lt_cnt ? DP_SORT_RD : DP_NONE;
			S_SORT_KEY: act = DP_SORT_KEY;
			S_SORT_J:   act = sts.j_nz ? DP_SORT_JRD : DP_SORT_PUT;
			S_SORT_CMP: act = sts.gt ? DP_SORT_SHIFT : DP_SORT_PUT;
			S_SCAN:     act = sts.a_lt_cnt ? DP_SCAN_RD : DP_NONE;
			S_SCAN_CMP: act = DP_SCAN_CMP;
			S_READ_RD:  act = DP_READ_RD;
			S_READ_CAP: act = DP_READ_CAP;
			S_FIN:      act = sts.out_free ? DP_OUT : DP_NONE;
			default:    act = DP_NONE;
		endcase
	end

	assign req_stall = (state_q != S_IDLE);
endmodule

@@ sv/iase_dp.sv @@
// Datapath of the indexed array store engine: element RAM, count, walk
// indices, accumulators and the result register. Depends on iase_pkg and iase_ram.
module iase_dp #(
	parameter int DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  iase_pkg::dp_act_t  act,
	output iase_pkg::dp_sts_t  sts,
	input  logic [2:0]         operation,
	input  logic [6:0]         position,
	input  logic signed [31:0] operand_value,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [2:0]         status,
	output logic signed [31:0] result_value,
	output logic [5:0]         result_index,
	output logic [6:0]         element_count
);
	import iase_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = ((CW > 7) ? CW : 7) + 1;

	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      a_q;
	logic [AW-1:0]      j_q;
	logic signed [31:0] key_q;
	logic signed [31:0] acc_q;
	logic signed [31:0] val_q;
	logic [1:0]         hits_q;
	logic [AW-1:0]      at_q;
	logic [6:0]         pos_q;
	op_t                op_q;
	status_t            err_q;
	logic               rsp_valid_q;
	status_t            status_q;
	logic signed [31:0] rval_q;
	logic [5:0]         ridx_q;
	logic [6:0]         cnt_out_q;

	op_t                in_op;
	status_t            in_err;
	logic [XW-1:0]      pos_x;
	logic [XW-1:0]      cnt_x;
	logic               full;
	logic               ram_we;
	logic [AW-1:0]      waddr;
	logic signed [31:0] wdata;
	logic [CW-1:0]      raddr_c;
	logic signed [31:0] rdata;
	status_t            fin_status;
	logic               fin_ok;

	assign in_op = op_t'(operation);
	assign pos_x = XW'(position);
	assign cnt_x = XW'(cnt_q);
	assign full  = (cnt_q == CW'(DEPTH));

	always_comb begin
		in_err = ST_OK;
		case (in_op)
			OP_APPEND: begin
				if (full) begin
					in_err = ST_FULL;
				end
			end
			OP_INSERT: begin
				if (full) begin
					in_err = ST_FULL;
				end else if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
					in_err = ST_POS;
				end
			end
			OP_DELETE: begin
				if (cnt_q == '0) begin
					in_err = ST_EMPTY;
				end else if (pos_x == '0 || pos_x > cnt_x) begin
					in_err = ST_POS;
				end
			end
			OP_MAX: begin
				if (cnt_q == '0) begin
					in_err = ST_EMPTY;
				end
			end
			OP_READ: begin
				if (pos_x >= cnt_x) begin
					in_err = ST_POS;
				end
			end
			default: in_err = ST_OK;
		endcase
	end

	always_comb begin
		ram_we  = 1'b0;
		waddr   = a_q[AW-1:0];
		wdata   = rdata;
		raddr_c = a_q;
		case (act)
			DP_ACCEPT: begin
				ram_we = (in_op == OP_APPEND) && (in_err == ST_OK);
				waddr  = cnt_q[AW-1:0];
				wdata  = operand_value;
			end
			DP_INS_RD:     raddr_c = a_q - CW'(1);
			DP_INS_WR:     ram_we = 1'b1;
			DP_INS_PUT: begin
				ram_we = 1'b1;
				wdata  = val_q;
			end
			DP_DEL_RD:     raddr_c = a_q + CW'(1);
			DP_DEL_WR:     ram_we = 1'b1;
			DP_SORT_JRD:   raddr_c = CW'(j_q) - CW'(1);
			DP_SORT_SHIFT: begin
				ram_we = 1'b1;
				waddr  = j_q;
			end
			DP_SORT_PUT: begin
				ram_we = 1'b1;
				waddr  = j_q;
				wdata  = key_q;
			end
			DP_READ_RD:    raddr_c = CW'(pos_q);
			default:       raddr_c = a_q;
		endcase
	end

	iase_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr_c[AW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (act == DP_OUT) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (act)
				DP_ACCEPT: begin
					if (in_op == OP_CLEAR) begin
						cnt_q <= '0;
					end else if (in_op == OP_APPEND && in_err == ST_OK) begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				DP_INS_PUT: cnt_q <= cnt_q + CW'(1);
				DP_DEL_END: cnt_q <= cnt_q - CW'(1);
				default:    cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (act)
			DP_ACCEPT: begin
				op_q   <= in_op;
				pos_q  <= position;
				val_q  <= operand_value;
				err_q  <= in_err;
				hits_q <= '0;
				at_q   <= '0;
				acc_q  <= '0;
				case (in_op)
					OP_INSERT: a_q <= cnt_q;
					OP_DELETE: a_q <= CW'(position - 7'd1);
					OP_SORT:   a_q <= CW'(1);
					default:   a_q <= '0;
				endcase
			end
			DP_INS_WR:   a_q <= a_q - CW'(1);
			DP_DEL_WR:   a_q <= a_q + CW'(1);
			DP_SORT_KEY: begin
				key_q <= rdata;
				j_q   <= a_q[AW-1:0];
			end
			DP_SORT_SHIFT: j_q <= j_q - AW'(1);
			DP_SORT_PUT:   a_q <= a_q + CW'(1);
			DP_SCAN_CMP: begin
				a_q <= a_q + CW'(1);
				if (op_q == OP_FIND) begin
					if (rdata == val_q) begin
						at_q <= a_q[AW-1:0];
						if (hits_q != 2'd2) begin
							hits_q <= hits_q + 2'd1;
						end
					end
				end else if (a_q == '0 || rdata > acc_q) begin
					acc_q <= rdata;
				end
			end
			DP_READ_CAP: acc_q <= rdata;
			DP_OUT: begin
				status_q  <= fin_status;
				rval_q    <= (fin_ok && (op_q == OP_MAX || op_q == OP_READ)) ? acc_q : '0;
				ridx_q    <= (fin_ok && op_q == OP_FIND) ? 6'(at_q) : '0;
				cnt_out_q <= 7'(cnt_q);
			end
			default: a_q <= a_q;
		endcase
	end

	always_comb begin
		fin_status = err_q;
		if (err_q == ST_OK && op_q == OP_FIND && hits_q != 2'd1) begin
			fin_status = ST_MISS;
		end
	end

	assign fin_ok = (fin_status == ST_OK);

	assign sts.err       = (in_err != ST_OK);
	assign sts.a_ge_pos  = XW'(a_q) >= XW'(pos_q);
	assign sts.a1_lt_cnt = (XW'(a_q) + XW'(1)) < cnt_x;
	assign sts.a_lt_cnt  = a_q < cnt_q;
	assign sts.j_nz      = (j_q != '0);
	assign sts.gt        = rdata > key_q;
	assign sts.out_free  = !rsp_valid_q || !rsp_stall;

	assign rsp_valid     = rsp_valid_q;
	assign status        = status_q;
	assign result_value  = rval_q;
	assign result_index  = ridx_q;
	assign element_count = cnt_out_q;
endmodule

@@ sv/indexed_array_store_engine.sv @@
// Indexed array store engine: an ordered store of up to DEPTH signed words in one RAM,
// with clear, append, insert, delete, insertion sort, find, maximum and read.
// Depends on iase_pkg, iase_ctrl and iase_dp.
//
// One request is worked at a time; every request gives one response. The store sits in a
// single RAM with one read and one write port and a registered read, and that port sets
// the time: insert and delete take longer with each entry moved, find and maximum with
// each stored entry, and sort with each entry and each entry shifted (quadratic in the
// worst case). A finished response waits in its own register, so the next request may be
// taken while it is still unclaimed; that request then holds in its final state until the
// waiting response is taken. Reset leaves the store empty and needs no clearing pass.
module indexed_array_store_engine #(
	parameter int DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [2:0]         operation,
	input  logic [6:0]         position,
	input  logic signed [31:0] operand_value,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [2:0]         status,
	output logic signed [31:0] result_value,
	output logic [5:0]         result_index,
	output logic [6:0]         element_count
);
	import iase_pkg::*;

	dp_act_t act;
	dp_sts_t sts;

	iase_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.operation(operation),
		.sts      (sts),
		.act      (act)
	);

	iase_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.act          (act),
		.sts          (sts),
		.operation    (operation),
		.position     (position),
		.operand_value(operand_value),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.status       (status),
		.result_value (result_value),
		.result_index (result_index),
		.element_count(element_count)
	);
endmodule
